>>> rtl/core/crdg_pkg.sv
// Package for the camera ray direction generator.
// Holds widths, fixed-point constants and shared types; depends on nothing.
package crdg_pkg;

   localparam int MAX_SIDE  = 4096;
   localparam int FRAC_BITS = 14;

   localparam int SIDE_W  = 13;                 // frame size register width
   localparam int COORD_W = 12;                 // pixel coordinate width
   localparam int MAG_W   = 12;                 // |2x+1-W| fits in 12 bits
   localparam int TAN_W   = 15;
   localparam int V_W     = 29;                 // scaled ray component, up to 2^28
   localparam int SQ_W    = 58;                 // sum of three squares
   localparam int ROOT_W  = SQ_W / 2;           // integer square root width
   localparam int REM_W   = ROOT_W + 3;         // square root partial remainder
   localparam int Q_W     = FRAC_BITS + 1;      // quotient, up to 2^FRAC_BITS
   localparam int DIVD_W  = V_W + FRAC_BITS + 1;
   localparam int OUT_W   = 16;
   localparam int CSR_IDX_W = 2;

   // tan(22.5 deg) in Q0.16.
   localparam logic [TAN_W-1:0] TAN_Q16 = TAN_W'(27146);

   localparam logic [SIDE_W-1:0] WIDTH_RESET  = SIDE_W'(640);
   localparam logic [SIDE_W-1:0] HEIGHT_RESET = SIDE_W'(480);

   // Pipeline depths, used for the latency figure.
   localparam int FRONT_STAGES = 4;
   localparam int DIV_STAGES   = Q_W + 1;
   localparam int LATENCY      = FRONT_STAGES + ROOT_W + DIV_STAGES + 1;

   typedef enum logic [CSR_IDX_W-1:0] {
      REG_FRAME_WIDTH  = 2'd0,
      REG_FRAME_HEIGHT = 2'd1
   } csr_index_type;

   // Unnormalized ray and its flags, carried alongside the arithmetic.
   typedef struct packed {
      logic           ok;
      logic           neg_x;
      logic           neg_y;
      logic [V_W-1:0] vx;
      logic [V_W-1:0] vy;
      logic [V_W-1:0] vz;
   } ray_type;

endpackage

>>> rtl/core/crdg_front.sv
// Front end: frame check, integer ray (a*t, b*t, H*2^16) and sum of squares.
// Four register stages; uses crdg_pkg.
module crdg_front (
   input  logic                            clock,
   input  logic                            reset,
   input  logic                            in_valid,
   input  logic [crdg_pkg::COORD_W-1:0]    pixel_x,
   input  logic [crdg_pkg::COORD_W-1:0]    pixel_y,
   input  logic [crdg_pkg::SIDE_W-1:0]     frame_width,
   input  logic [crdg_pkg::SIDE_W-1:0]     frame_height,
   output logic                            out_valid,
   output crdg_pkg::ray_type               out_ray,
   output logic [crdg_pkg::SQ_W-1:0]       out_sum
);

   localparam int SW = crdg_pkg::SIDE_W;
   localparam int MW = crdg_pkg::MAG_W;
   localparam int VW = crdg_pkg::V_W;
   localparam int QW = crdg_pkg::SQ_W;

   logic [SW-1:0] w_clamp, h_clamp;
   logic signed [SW:0] a_in, b_in;
   logic ok_in;

   logic          s1_vld_ff, s2_vld_ff, s3_vld_ff, s4_vld_ff;
   logic          s1_ok_ff, s1_nx_ff, s1_ny_ff;
   logic [MW-1:0] s1_ax_ff, s1_ay_ff;
   logic [SW-1:0] s1_h_ff;
   crdg_pkg::ray_type s2_ray_ff, s3_ray_ff, s4_ray_ff;
   logic [QW-1:0] s3_sx_ff, s3_sy_ff, s3_sz_ff, s4_sum_ff;

   always_comb begin
      w_clamp = (frame_width > SW'(crdg_pkg::MAX_SIDE)) ? SW'(crdg_pkg::MAX_SIDE) : frame_width;
      h_clamp = (frame_height > SW'(crdg_pkg::MAX_SIDE)) ? SW'(crdg_pkg::MAX_SIDE) : frame_height;
      ok_in = ({1'b0, pixel_x} < w_clamp) && ({1'b0, pixel_y} < h_clamp);
      a_in = $signed({1'b0, pixel_x, 1'b1}) - $signed({1'b0, w_clamp});
      b_in = $signed({1'b0, h_clamp}) - $signed({1'b0, pixel_y, 1'b1});
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         s1_vld_ff <= 1'b0;
         s2_vld_ff <= 1'b0;
         s3_vld_ff <= 1'b0;
         s4_vld_ff <= 1'b0;
      end else begin
         s1_vld_ff <= in_valid;
         s2_vld_ff <= s1_vld_ff;
         s3_vld_ff <= s2_vld_ff;
         s4_vld_ff <= s3_vld_ff;
      end
   end

   always_ff @(posedge clock) begin
      // Stage 1: signed offsets from the frame center, split into sign and magnitude.
      s1_ok_ff <= ok_in;
      s1_nx_ff <= a_in[SW];
      s1_ny_ff <= b_in[SW];
      s1_ax_ff <= a_in[SW] ? MW'(-a_in) : MW'(a_in);
      s1_ay_ff <= b_in[SW] ? MW'(-b_in) : MW'(b_in);
      s1_h_ff  <= h_clamp;
      // Stage 2: scale by the field-of-view tangent.
      s2_ray_ff.ok    <= s1_ok_ff;
      s2_ray_ff.neg_x <= s1_nx_ff;
      s2_ray_ff.neg_y <= s1_ny_ff;
      s2_ray_ff.vx    <= VW'(s1_ax_ff) * VW'(crdg_pkg::TAN_Q16);
      s2_ray_ff.vy    <= VW'(s1_ay_ff) * VW'(crdg_pkg::TAN_Q16);
      s2_ray_ff.vz    <= {s1_h_ff, 16'd0};
      // Stage 3: squares.
      s3_ray_ff <= s2_ray_ff;
      s3_sx_ff  <= s2_ray_ff.vx * s2_ray_ff.vx;
      s3_sy_ff  <= s2_ray_ff.vy * s2_ray_ff.vy;
      s3_sz_ff  <= s2_ray_ff.vz * s2_ray_ff.vz;
      // Stage 4: squared length.
      s4_ray_ff <= s3_ray_ff;
      s4_sum_ff <= s3_sx_ff + s3_sy_ff + s3_sz_ff;
   end

   assign out_valid = s4_vld_ff;
   assign out_ray   = s4_ray_ff;
   assign out_sum   = s4_sum_ff;

endmodule

>>> rtl/core/crdg_sqrt.sv
// Pipelined integer square root, one result bit per register stage.
// Carries the ray alongside; uses crdg_pkg.
module crdg_sqrt (
   input  logic                         clock,
   input  logic                         reset,
   input  logic                         in_valid,
   input  crdg_pkg::ray_type            in_ray,
   input  logic [crdg_pkg::SQ_W-1:0]    in_rad,
   output logic                         out_valid,
   output crdg_pkg::ray_type            out_ray,
   output logic [crdg_pkg::ROOT_W-1:0]  out_root
);

   localparam int RW = crdg_pkg::ROOT_W;
   localparam int EW = crdg_pkg::REM_W;
   localparam int QW = crdg_pkg::SQ_W;

   logic              vld_q  [RW+1];
   crdg_pkg::ray_type ray_q  [RW+1];
   logic [QW-1:0]     rad_q  [RW+1];
   logic [EW-1:0]     rem_q  [RW+1];
   logic [RW-1:0]     root_q [RW+1];

   assign vld_q[0]  = in_valid;
   assign ray_q[0]  = in_ray;
   assign rad_q[0]  = in_rad;
   assign rem_q[0]  = '0;
   assign root_q[0] = '0;

   for (genvar k = 0; k < RW; k++) begin : g_step
      localparam int P = RW - 1 - k;   // radicand bit pair consumed here
      logic [EW-1:0] cur, trial;
      logic          take;
      logic          vld_ff;
      crdg_pkg::ray_type ray_ff;
      logic [QW-1:0] rad_ff;
      logic [EW-1:0] rem_ff;
      logic [RW-1:0] root_ff;

      always_comb begin
         cur   = {rem_q[k][EW-3:0], rad_q[k][2*P+1 -: 2]};
         trial = EW'({root_q[k], 2'b01});
         take  = (cur >= trial);
      end

      always_ff @(posedge clock) begin
         if (reset) begin
            vld_ff <= 1'b0;
         end else begin
            vld_ff <= vld_q[k];
         end
      end

      always_ff @(posedge clock) begin
         ray_ff  <= ray_q[k];
         rad_ff  <= rad_q[k];
         rem_ff  <= take ? (cur - trial) : cur;
         root_ff <= {root_q[k][RW-2:0], take};
      end

      assign vld_q[k+1]  = vld_ff;
      assign ray_q[k+1]  = ray_ff;
      assign rad_q[k+1]  = rad_ff;
      assign rem_q[k+1]  = rem_ff;
      assign root_q[k+1] = root_ff;
   end

   assign out_valid = vld_q[RW];
   assign out_ray   = ray_q[RW];
   assign out_root  = root_q[RW];

endmodule

>>> rtl/core/crdg_div.sv
// Pipelined restoring divider for the three components, rounded to nearest.
// One quotient bit per stage on all three lanes; uses crdg_pkg.
module crdg_div (
   input  logic                         clock,
   input  logic                         reset,
   input  logic                         in_valid,
   input  crdg_pkg::ray_type            in_ray,
   input  logic [crdg_pkg::ROOT_W-1:0]  in_norm,
   output logic                         out_valid,
   output logic                         out_ok,
   output logic                         out_neg_x,
   output logic                         out_neg_y,
   output logic [crdg_pkg::Q_W-1:0]     out_qx,
   output logic [crdg_pkg::Q_W-1:0]     out_qy,
   output logic [crdg_pkg::Q_W-1:0]     out_qz
);

   localparam int NW = crdg_pkg::ROOT_W;
   localparam int QW = crdg_pkg::Q_W;
   localparam int DW = crdg_pkg::DIVD_W;
   localparam int FB = crdg_pkg::FRAC_BITS;

   logic [DW-1:0] divd_in [3];
   logic [crdg_pkg::V_W-1:0] mag [3];

   logic          vld_q  [QW+1];
   logic [2:0]    flg_q  [QW+1];       // ok, neg_x, neg_y
   logic [NW-1:0] den_q  [QW+1];
   logic [NW-1:0] rem_q  [QW+1][3];
   logic [QW-1:0] low_q  [QW+1][3];    // unconsumed dividend bits
   logic [QW-1:0] quo_q  [QW+1][3];

   logic          p_vld_ff;
   logic [2:0]    p_flg_ff;
   logic [NW-1:0] p_den_ff;
   logic [DW-1:0] p_divd_ff [3];

   assign mag[0] = in_ray.vx;
   assign mag[1] = in_ray.vy;
   assign mag[2] = in_ray.vz;

   always_comb begin
      for (int c = 0; c < 3; c++) begin
         divd_in[c] = {1'b0, mag[c], FB'(0)} + DW'(in_norm >> 1);
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         p_vld_ff <= 1'b0;
      end else begin
         p_vld_ff <= in_valid;
      end
   end

   always_ff @(posedge clock) begin
      p_flg_ff <= {in_ray.ok, in_ray.neg_x, in_ray.neg_y};
      p_den_ff <= in_norm;
      for (int c = 0; c < 3; c++) begin
         p_divd_ff[c] <= divd_in[c];
      end
   end

   // The quotient stays below 2^QW, so the high dividend part is already below the divisor.
   assign vld_q[0] = p_vld_ff;
   assign flg_q[0] = p_flg_ff;
   assign den_q[0] = p_den_ff;
   for (genvar c = 0; c < 3; c++) begin : g_init
      assign rem_q[0][c] = p_divd_ff[c][DW-1 -: NW];
      assign low_q[0][c] = p_divd_ff[c][QW-1:0];
      assign quo_q[0][c] = '0;
   end

   for (genvar k = 0; k < QW; k++) begin : g_step
      logic          vld_ff;
      logic [2:0]    flg_ff;
      logic [NW-1:0] den_ff;

      always_ff @(posedge clock) begin
         if (reset) begin
            vld_ff <= 1'b0;
         end else begin
            vld_ff <= vld_q[k];
         end
      end

      always_ff @(posedge clock) begin
         flg_ff <= flg_q[k];
         den_ff <= den_q[k];
      end

      assign vld_q[k+1] = vld_ff;
      assign flg_q[k+1] = flg_ff;
      assign den_q[k+1] = den_ff;

      for (genvar c = 0; c < 3; c++) begin : g_lane
         logic [NW:0]   part;
         logic          take;
         logic [NW-1:0] rem_ff;
         logic [QW-1:0] low_ff, quo_ff;

         always_comb begin
            part = {rem_q[k][c], low_q[k][c][QW-1]};
            take = (part >= {1'b0, den_q[k]});
         end

         always_ff @(posedge clock) begin
            rem_ff <= take ? NW'(part - {1'b0, den_q[k]}) : NW'(part);
            low_ff <= {low_q[k][c][QW-2:0], 1'b0};
            quo_ff <= {quo_q[k][c][QW-2:0], take};
         end

         assign rem_q[k+1][c] = rem_ff;
         assign low_q[k+1][c] = low_ff;
         assign quo_q[k+1][c] = quo_ff;
      end
   end

   assign out_valid = vld_q[QW];
   assign out_ok    = flg_q[QW][2];
   assign out_neg_x = flg_q[QW][1];
   assign out_neg_y = flg_q[QW][0];
   assign out_qx    = quo_q[QW][0];
   assign out_qy    = quo_q[QW][1];
   assign out_qz    = quo_q[QW][2];

endmodule

>>> rtl/core/camera_ray_direction_generator.sv
// Pinhole camera primary ray direction generator, 45 degree field of view.
// Path from the start edge to the rsp_valid strobe: 4 front stages, 29 square root
// stages, 16 divider stages and the output register.
// Throughput: one transaction per cycle; busy is always low and the receiver cannot stall.
// Reset (synchronous, active high) empties the pipeline and sets the frame to 640 x 480.
// Depends on crdg_pkg, crdg_front, crdg_sqrt and crdg_div.
module camera_ray_direction_generator (
   input  logic                                 clock,
   input  logic                                 reset,
   // Pixel coordinate transactions.
   input  logic                                 start,
   output logic                                 busy,
   input  logic [crdg_pkg::COORD_W-1:0]         req_pixel_x,
   input  logic [crdg_pkg::COORD_W-1:0]         req_pixel_y,
   // Ray direction results, one cycle strobe.
   output logic                                 rsp_valid,
   output logic signed [crdg_pkg::OUT_W-1:0]    rsp_dir_x,
   output logic signed [crdg_pkg::OUT_W-1:0]    rsp_dir_y,
   output logic [crdg_pkg::Q_W-1:0]             rsp_dir_z,
   output logic                                 rsp_coord_ok,
   // Frame size registers.
   input  logic                                 csr_valid,
   output logic                                 csr_ready,
   input  logic [crdg_pkg::CSR_IDX_W-1:0]       csr_index,
   input  logic [crdg_pkg::SIDE_W-1:0]          csr_wdata
);

   localparam int OW = crdg_pkg::OUT_W;
   localparam int QW = crdg_pkg::Q_W;

   logic [crdg_pkg::SIDE_W-1:0] frame_width_ff, frame_height_ff;

   logic                        fr_valid, sq_valid, dv_valid;
   crdg_pkg::ray_type           fr_ray, sq_ray;
   logic [crdg_pkg::SQ_W-1:0]   fr_sum;
   logic [crdg_pkg::ROOT_W-1:0] sq_root;
   logic                        dv_ok, dv_neg_x, dv_neg_y;
   logic [QW-1:0]               dv_qx, dv_qy, dv_qz;

   logic                        rsp_valid_ff, rsp_ok_ff;
   logic [OW-1:0]               rsp_x_ff, rsp_y_ff, rsp_x_in, rsp_y_in;
   logic [QW-1:0]               rsp_z_ff, rsp_z_in;

   // Every stage advances each cycle, so a transaction is taken whenever start is high.
   assign busy      = 1'b0;
   assign csr_ready = 1'b1;

   // Configuration registers. Writes to unknown indexes are dropped.
   always_ff @(posedge clock) begin
      if (reset) begin
         frame_width_ff  <= crdg_pkg::WIDTH_RESET;
         frame_height_ff <= crdg_pkg::HEIGHT_RESET;
      end else if (csr_valid && csr_ready) begin
         case (crdg_pkg::csr_index_type'(csr_index))
            crdg_pkg::REG_FRAME_WIDTH:  frame_width_ff  <= csr_wdata;
            crdg_pkg::REG_FRAME_HEIGHT: frame_height_ff <= csr_wdata;
            default: ;
         endcase
      end
   end

   // The front end checks the coordinate and forms the squared ray length.
   crdg_front u_front (
      .clock        (clock),
      .reset        (reset),
      .in_valid     (start && !busy),
      .pixel_x      (req_pixel_x),
      .pixel_y      (req_pixel_y),
      .frame_width  (frame_width_ff),
      .frame_height (frame_height_ff),
      .out_valid    (fr_valid),
      .out_ray      (fr_ray),
      .out_sum      (fr_sum)
   );

   // The ray length is the floor of the square root of the sum of squares.
   crdg_sqrt u_sqrt (
      .clock     (clock),
      .reset     (reset),
      .in_valid  (fr_valid),
      .in_ray    (fr_ray),
      .in_rad    (fr_sum),
      .out_valid (sq_valid),
      .out_ray   (sq_ray),
      .out_root  (sq_root)
   );

   // Each component magnitude is divided by the length with round half up.
   crdg_div u_div (
      .clock     (clock),
      .reset     (reset),
      .in_valid  (sq_valid),
      .in_ray    (sq_ray),
      .in_norm   (sq_root),
      .out_valid (dv_valid),
      .out_ok    (dv_ok),
      .out_neg_x (dv_neg_x),
      .out_neg_y (dv_neg_y),
      .out_qx    (dv_qx),
      .out_qy    (dv_qy),
      .out_qz    (dv_qz)
   );

   // Apply signs. Outside the frame the quotients are meaningless and are forced to zero.
   always_comb begin
      rsp_x_in = '0;
      rsp_y_in = '0;
      rsp_z_in = '0;
      if (dv_ok) begin
         rsp_x_in = dv_neg_x ? (OW'(0) - OW'(dv_qx)) : OW'(dv_qx);
         rsp_y_in = dv_neg_y ? (OW'(0) - OW'(dv_qy)) : OW'(dv_qy);
         rsp_z_in = dv_qz;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else begin
         rsp_valid_ff <= dv_valid;
      end
   end

   always_ff @(posedge clock) begin
      rsp_ok_ff <= dv_ok;
      rsp_x_ff  <= rsp_x_in;
      rsp_y_ff  <= rsp_y_in;
      rsp_z_ff  <= rsp_z_in;
   end

   assign rsp_valid    = rsp_valid_ff;
   assign rsp_coord_ok = rsp_ok_ff;
   assign rsp_dir_x    = rsp_x_ff;
   assign rsp_dir_y    = rsp_y_ff;
   assign rsp_dir_z    = rsp_z_ff;

   // A ray inside the frame always points forward.
   a_z_forward: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_coord_ok |-> rsp_dir_z != '0)
      else $error("forward component is zero for an in-frame ray");

   // A coordinate outside the frame gives an all-zero direction.
   a_outside_zero: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_coord_ok |->
         (rsp_dir_x == '0) && (rsp_dir_y == '0) && (rsp_dir_z == '0))
      else $error("nonzero direction for a coordinate outside the frame");

   // The vertical offset is below the frame height and the tangent is below one,
   // so the y component never exceeds the z component.
   a_z_ge_y: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_coord_ok |->
         (rsp_dir_y[OW-1] ? OW'(-rsp_dir_y) : rsp_dir_y) <= OW'(rsp_dir_z))
      else $error("y component exceeds z component");

endmodule

>>> verif/testbench.sv
// Self-checking testbench for camera_ray_direction_generator.
// Drives pixel coordinates and frame size writes, predicts each unit ray direction
// in fixed point and compares it field by field; depends on crdg_pkg and the RTL.
`timescale 1ns / 100ps

module testbench;

   localparam int IW = crdg_pkg::CSR_IDX_W;
   localparam int SW = crdg_pkg::SIDE_W;
   localparam int CW = crdg_pkg::COORD_W;
   localparam int OW = crdg_pkg::OUT_W;
   localparam int ZW = crdg_pkg::Q_W;

   // Register indexes that the block does not decode. Writes to them must be ignored.
   localparam logic [IW-1:0] REG_SPARE_2 = 2'd2;
   localparam logic [IW-1:0] REG_SPARE_3 = 2'd3;
   localparam int unsigned TAN_SCALED = 27146;  // tan(22.5 deg) * 2^16, rounded
   localparam int DRAIN_CYCLES   = crdg_pkg::LATENCY + 10;
   localparam int WATCHDOG_LIMIT = 2000;
   localparam int RANDOM_PHASES  = 8;
   localparam int ITEMS_PER_PHASE = 160;

   typedef struct packed {
      logic signed [OW-1:0] dir_x;
      logic signed [OW-1:0] dir_y;
      logic [ZW-1:0]        dir_z;
      logic                 coord_ok;
   } ray_dir_type;

   typedef enum logic {ROW_WRITE, ROW_PIXEL} row_kind_type;

   typedef struct {
      row_kind_type      kind;
      logic [IW-1:0]     index;
      logic [SW-1:0]     data;
      logic [CW-1:0]     x;
      logic [CW-1:0]     y;
      bit                typed;   // expectation given in the row itself
      ray_dir_type       want;
   } stim_row_type;

   localparam ray_dir_type OUTSIDE_FRAME = '{16'sd0, 16'sd0, 15'd0, 1'b0};
   localparam ray_dir_type STRAIGHT_AHEAD = '{16'sd0, 16'sd0, 15'd16384, 1'b1};

   localparam logic [IW-1:0] IDX_WIDTH  = crdg_pkg::REG_FRAME_WIDTH;
   localparam logic [IW-1:0] IDX_HEIGHT = crdg_pkg::REG_FRAME_HEIGHT;

   logic clock = 1'b0;
   logic reset = 1'b1;
   logic start = 1'b0;
   logic [CW-1:0] req_pixel_x = '0;
   logic [CW-1:0] req_pixel_y = '0;
   logic csr_valid = 1'b0;
   logic [IW-1:0] csr_index = IDX_WIDTH;
   logic [SW-1:0] csr_wdata = '0;
   logic busy, rsp_valid, rsp_coord_ok, csr_ready;
   logic signed [OW-1:0] rsp_dir_x, rsp_dir_y;
   logic [ZW-1:0] rsp_dir_z;

   // Our own copy of the frame size registers, updated on every accepted write.
   logic [SW-1:0] width_reg = crdg_pkg::WIDTH_RESET;
   logic [SW-1:0] height_reg = crdg_pkg::HEIGHT_RESET;

   ray_dir_type pending_rays[$];
   int error_count = 0;
   int pixel_count = 0;
   int result_count = 0;
   int write_count = 0;
   int idle_cycles = 0;
   bit no_idling = 1'b0;

   camera_ray_direction_generator uut (
      .clock(clock), .reset(reset),
      .start(start), .busy(busy),
      .req_pixel_x(req_pixel_x), .req_pixel_y(req_pixel_y),
      .rsp_valid(rsp_valid), .rsp_dir_x(rsp_dir_x), .rsp_dir_y(rsp_dir_y),
      .rsp_dir_z(rsp_dir_z), .rsp_coord_ok(rsp_coord_ok),
      .csr_valid(csr_valid), .csr_ready(csr_ready),
      .csr_index(csr_index), .csr_wdata(csr_wdata)
   );

   initial begin
      forever #6 clock = ~clock;
   end

   // Exact floor square root, one result bit per pass.
   function automatic longint unsigned floor_sqrt(longint unsigned radicand);
      longint unsigned root, probe;
      root = 0;
      for (int b = 31; b >= 0; b--) begin
         probe = root | (64'd1 << b);
         if (probe * probe <= radicand) root = probe;
      end
      return root;
   endfunction

   // Sizes above MAX_SIDE behave as MAX_SIDE.
   function automatic longint unsigned frame_side(logic [SW-1:0] reg_value);
      return (reg_value > crdg_pkg::MAX_SIDE) ? crdg_pkg::MAX_SIDE : reg_value;
   endfunction

   // Unit ray through the pixel center, rounded half up in Q1.14 per component.
   function automatic ray_dir_type predict_ray(logic [CW-1:0] x, logic [CW-1:0] y);
      longint unsigned w, h, vx, vy, vz, norm, mx, my, mz;
      longint signed a, b;
      ray_dir_type ray;
      w = frame_side(width_reg);
      h = frame_side(height_reg);
      if (x >= w || y >= h) return OUTSIDE_FRAME;
      a = longint'(2 * x + 1) - longint'(w);
      b = longint'(h) - longint'(2 * y + 1);
      vx = ((a < 0) ? -a : a) * TAN_SCALED;
      vy = ((b < 0) ? -b : b) * TAN_SCALED;
      vz = h << 16;
      norm = floor_sqrt(vx * vx + vy * vy + vz * vz);
      mx = ((vx << crdg_pkg::FRAC_BITS) + (norm >> 1)) / norm;
      my = ((vy << crdg_pkg::FRAC_BITS) + (norm >> 1)) / norm;
      mz = ((vz << crdg_pkg::FRAC_BITS) + (norm >> 1)) / norm;
      ray.dir_x = (a < 0) ? -OW'(mx) : OW'(mx);
      ray.dir_y = (b < 0) ? -OW'(my) : OW'(my);
      ray.dir_z = ZW'(mz);
      ray.coord_ok = 1'b1;
      return ray;
   endfunction

   task automatic report_mismatch(string field, longint got, longint want);
      $display("[%0t] mismatch on %s: got %0d, expected %0d", $realtime, field, got, want);
      error_count++;
   endtask

   // Result checker. Results cannot be held off, so every strobe is a transaction.
   always @(posedge clock) begin
      ray_dir_type want;
      if (!reset && rsp_valid) begin
         result_count++;
         if (pending_rays.size() == 0) begin
            $display("[%0t] result transaction with nothing expected", $realtime);
            error_count++;
         end else begin
            want = pending_rays.pop_front();
            if (rsp_dir_x !== want.dir_x) report_mismatch("dir_x", rsp_dir_x, want.dir_x);
            if (rsp_dir_y !== want.dir_y) report_mismatch("dir_y", rsp_dir_y, want.dir_y);
            if (rsp_dir_z !== want.dir_z) report_mismatch("dir_z", rsp_dir_z, want.dir_z);
            if (rsp_coord_ok !== want.coord_ok)
               report_mismatch("coord_ok", rsp_coord_ok, want.coord_ok);
         end
      end
   end

   // Watchdog: any accepted transaction on any channel counts as progress.
   always @(posedge clock) begin
      if (reset || rsp_valid || (start && !busy) || (csr_valid && csr_ready)) begin
         idle_cycles <= 0;
      end else begin
         idle_cycles <= idle_cycles + 1;
         if (idle_cycles >= WATCHDOG_LIMIT) begin
            $display("[%0t] watchdog expired with %0d results outstanding",
                     $realtime, pending_rays.size());
            $display("CHECKS FAILED");
            $finish;
         end
      end
   end

   // Offers one pixel transaction after an optional random gap. The expectation is
   // queued at the edge that accepts it, so a typed row overrides the predictor.
   task automatic send_pixel(logic [CW-1:0] x, logic [CW-1:0] y,
                             bit typed, ray_dir_type want);
      while (!no_idling && $urandom_range(99) < 20) begin
         start <= 1'b0;
         @(posedge clock);
      end
      start <= 1'b1;
      req_pixel_x <= x;
      req_pixel_y <= y;
      do @(posedge clock); while (busy);
      pending_rays.push_back(typed ? want : predict_ray(x, y));
      pixel_count++;
   endtask

   // Holds off new pixels until every result is back, then lets the pipeline drain.
   task automatic wait_idle();
      start <= 1'b0;
      while (pending_rays.size() != 0) @(posedge clock);
      repeat (DRAIN_CYCLES) @(posedge clock);
   endtask

   task automatic write_register(logic [IW-1:0] index, logic [SW-1:0] data);
      while (!no_idling && $urandom_range(99) < 20) @(posedge clock);
      csr_valid <= 1'b1;
      csr_index <= index;
      csr_wdata <= data;
      do @(posedge clock); while (!csr_ready);
      if (index == IDX_WIDTH) width_reg = data;
      else if (index == IDX_HEIGHT) height_reg = data;
      write_count++;
      csr_valid <= 1'b0;
   endtask

   // Directed rows: reset frame, single pixel frame, zero width, clamped oversize
   // frame and writes to undecoded indexes.
   stim_row_type directed_rows[] = '{
      '{ROW_PIXEL, IDX_WIDTH,  13'd0,    12'd0,    12'd0,    1'b0, OUTSIDE_FRAME},
      '{ROW_PIXEL, IDX_WIDTH,  13'd0,    12'd639,  12'd479,  1'b0, OUTSIDE_FRAME},
      '{ROW_PIXEL, IDX_WIDTH,  13'd0,    12'd320,  12'd240,  1'b0, OUTSIDE_FRAME},
      '{ROW_PIXEL, IDX_WIDTH,  13'd0,    12'd639,  12'd0,    1'b0, OUTSIDE_FRAME},
      '{ROW_PIXEL, IDX_WIDTH,  13'd0,    12'd640,  12'd0,    1'b1, OUTSIDE_FRAME},
      '{ROW_PIXEL, IDX_WIDTH,  13'd0,    12'd0,    12'd480,  1'b1, OUTSIDE_FRAME},
      '{ROW_PIXEL, IDX_WIDTH,  13'd0,    12'd4095, 12'd4095, 1'b1, OUTSIDE_FRAME},
      '{ROW_WRITE, IDX_WIDTH,  13'd1,    12'd0,    12'd0,    1'b0, OUTSIDE_FRAME},
      '{ROW_WRITE, IDX_HEIGHT, 13'd1,    12'd0,    12'd0,    1'b0, OUTSIDE_FRAME},
      '{ROW_PIXEL, IDX_WIDTH,  13'd0,    12'd0,    12'd0,    1'b1, STRAIGHT_AHEAD},
      '{ROW_PIXEL, IDX_WIDTH,  13'd0,    12'd1,    12'd0,    1'b1, OUTSIDE_FRAME},
      '{ROW_WRITE, IDX_WIDTH,  13'd0,    12'd0,    12'd0,    1'b0, OUTSIDE_FRAME},
      '{ROW_PIXEL, IDX_WIDTH,  13'd0,    12'd0,    12'd0,    1'b1, OUTSIDE_FRAME},
      '{ROW_WRITE, IDX_WIDTH,  13'd8191, 12'd0,    12'd0,    1'b0, OUTSIDE_FRAME},
      '{ROW_WRITE, IDX_HEIGHT, 13'd4096, 12'd0,    12'd0,    1'b0, OUTSIDE_FRAME},
      '{ROW_PIXEL, IDX_WIDTH,  13'd0,    12'd4095, 12'd4095, 1'b0, OUTSIDE_FRAME},
      '{ROW_PIXEL, IDX_WIDTH,  13'd0,    12'd0,    12'd0,    1'b0, OUTSIDE_FRAME},
      '{ROW_PIXEL, IDX_WIDTH,  13'd0,    12'd2048, 12'd2048, 1'b0, OUTSIDE_FRAME},
      '{ROW_WRITE, REG_SPARE_2, 13'd0,   12'd0,    12'd0,    1'b0, OUTSIDE_FRAME},
      '{ROW_WRITE, REG_SPARE_3, 13'd8191, 12'd0,   12'd0,    1'b0, OUTSIDE_FRAME},
      '{ROW_PIXEL, IDX_WIDTH,  13'd0,    12'd4095, 12'd0,    1'b0, OUTSIDE_FRAME}
   };

   initial begin
      logic [SW-1:0] phase_w [RANDOM_PHASES] =
         '{13'd640, 13'd1, 13'd4096, 13'd8191, 13'd0, 13'd1, 13'd4096, 13'd37};
      logic [SW-1:0] phase_h [RANDOM_PHASES] =
         '{13'd480, 13'd1, 13'd4096, 13'd5000, 13'd9, 13'd4096, 13'd1, 13'd0};
      longint unsigned w, h;
      logic [CW-1:0] x, y;
      repeat (7) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      foreach (directed_rows[i]) begin
         if (directed_rows[i].kind == ROW_WRITE) begin
            // The frame size only changes while nothing is in flight.
            wait_idle();
            write_register(directed_rows[i].index, directed_rows[i].data);
         end else begin
            send_pixel(directed_rows[i].x, directed_rows[i].y,
                       directed_rows[i].typed, directed_rows[i].want);
         end
      end

      // Random phases, one frame size each. The last phase size is partly random.
      // Most pixels fall inside the frame; the rest hit borders or anywhere at all.
      phase_w[RANDOM_PHASES-1] = SW'($urandom_range(1, 4096));
      for (int p = 0; p < RANDOM_PHASES; p++) begin
         wait_idle();
         write_register(IDX_WIDTH, phase_w[p]);
         write_register(IDX_HEIGHT, phase_h[p]);
         write_register($urandom_range(1) ? REG_SPARE_2 : REG_SPARE_3, SW'($urandom));
         w = frame_side(width_reg);
         h = frame_side(height_reg);
         no_idling = (p == 2);   // one long back-to-back stretch
         for (int n = 0; n < ITEMS_PER_PHASE; n++) begin
            case ($urandom_range(9))
               0: begin
                  x = CW'($urandom);
                  y = CW'($urandom);
               end
               1: begin
                  x = (w == 0) ? '0 : CW'($urandom_range(1) ? w - 1 : w);
                  y = (h == 0) ? '0 : CW'($urandom_range(1) ? 0 : h - 1);
               end
               default: begin
                  x = (w == 0) ? CW'($urandom) : CW'($urandom_range(0, w - 1));
                  y = (h == 0) ? CW'($urandom) : CW'($urandom_range(0, h - 1));
               end
            endcase
            send_pixel(x, y, 1'b0, OUTSIDE_FRAME);
         end
         no_idling = 1'b0;
      end

      wait_idle();
      $display("Covered %0d pixel transactions, %0d results and %0d register writes,",
               pixel_count, result_count, write_count);
      $display("over frames from empty and 1x1 up to clamped oversize sides.");
      if (error_count == 0) begin
         $display("ALL CHECKS PASSED");
      end else begin
         $display("CHECKS FAILED");
      end
      $finish;
   end

endmodule

>>> files.f
rtl/core/crdg_pkg.sv
rtl/core/crdg_front.sv
rtl/core/crdg_sqrt.sv
rtl/core/crdg_div.sv
rtl/core/camera_ray_direction_generator.sv
verif/testbench.sv
